FILE: sv/kbv_pkg.sv
// ---------------------------------------------------------------------------
// kbv_pkg
// Shared widths, constants and the job type of the knapsack best-value block.
// ---------------------------------------------------------------------------
`default_nettype none

package kbv_pkg;

	// field widths of the channels and the configuration register
	localparam int CAP_W    = 10;
	localparam int WEIGHT_W = 10;
	localparam int VALUE_W  = 16;
	localparam int RESULT_W = 32;

	// table size
	localparam int MAX_CAPACITY = 1023;
	localparam int VALUE_BITS   = 16;
	localparam int DEPTH        = MAX_CAPACITY + 1;
	localparam int ADDR_W       = $clog2(DEPTH);

	// width that holds both a weight and a table index for comparison
	localparam int CMP_W = (WEIGHT_W > ADDR_W) ? WEIGHT_W : ADDR_W;
	localparam int CAPCMP_W = (CAP_W > ADDR_W) ? CAP_W : ADDR_W;

	// only the low VALUE_BITS bits of an item value count
	localparam logic [VALUE_W-1:0] VALUE_MASK = (VALUE_BITS >= VALUE_W) ? {VALUE_W{1'b1}}
		: VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// one classified item as handed from front to back
	typedef struct packed {
		logic [ADDR_W-1:0]  weight;
		logic [VALUE_W-1:0] value;
		logic [ADDR_W-1:0]  cap;
		logic               last;
		logic               skip;
	} kbv_job_t;

endpackage

`default_nettype wire

FILE: sv/kbv_if.sv
// ---------------------------------------------------------------------------
// kbv_if
// Valid/ready channel interfaces for items in and results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface kbv_item_if;
	import kbv_pkg::*;

	logic                valid;
	logic                ready;
	logic [WEIGHT_W-1:0] item_weight;
	logic [VALUE_W-1:0]  item_value;
	logic                last_item;

	modport source (output valid, output item_weight, output item_value,
		output last_item, input ready);
	modport sink (input valid, input item_weight, input item_value,
		input last_item, output ready);
endinterface

interface kbv_result_if;
	import kbv_pkg::*;

	logic                valid;
	logic                ready;
	logic [RESULT_W-1:0] best_value;
	logic                saturated;

	modport source (output valid, output best_value, output saturated, input ready);
	modport sink (input valid, input best_value, input saturated, output ready);
endinterface

`default_nettype wire

FILE: sv/kbv_queue.sv
// ---------------------------------------------------------------------------
// kbv_queue
// Short first-in first-out queue of classified jobs between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module kbv_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire kbv_pkg::kbv_job_t push_job,
	output logic                  full,
	input  wire logic             pop,
	output kbv_pkg::kbv_job_t     head,
	output logic                  empty
);
	import kbv_pkg::*;

	kbv_job_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	// status
	always_comb begin
		full    = (count_q == QCNT_W'(QUEUE_DEPTH));
		empty   = (count_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		head    = entries_q[rd_ptr_q];
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// never more than the depth in flight
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_push_moves_wr: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> wr_ptr_q != $past(wr_ptr_q) || QUEUE_DEPTH == 1)
		else $error("push did not advance write pointer");

	a_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !push) |=> empty)
		else $error("queue filled without a push");

endmodule

`default_nettype wire

FILE: sv/kbv_front.sv
// ---------------------------------------------------------------------------
// kbv_front
// Takes items and the capacity register, classifies each item and queues it.
// ---------------------------------------------------------------------------
`default_nettype none

module kbv_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	kbv_item_if.sink                items,
	input  wire logic               capacity_we,
	input  wire logic [kbv_pkg::CAP_W-1:0] capacity_wdata,
	output logic                    push,
	output kbv_pkg::kbv_job_t       push_job,
	input  wire logic               full
);
	import kbv_pkg::*;

	logic [CAP_W-1:0]  capacity_q;
	logic [ADDR_W-1:0] active_cap;
	logic              too_heavy;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
		end else if (capacity_we) begin
			capacity_q <= capacity_wdata;
		end
	end

	// clamp capacity to the table and classify the item
	always_comb begin
		if (CAPCMP_W'(capacity_q) > CAPCMP_W'(MAX_CAPACITY)) begin
			active_cap = ADDR_W'(MAX_CAPACITY);
		end else begin
			active_cap = ADDR_W'(capacity_q);
		end
		too_heavy = CMP_W'(items.item_weight) > CMP_W'(active_cap);

		push_job.weight = ADDR_W'(items.item_weight);
		push_job.value  = items.item_value & VALUE_MASK;
		push_job.cap    = active_cap;
		push_job.last   = items.last_item;
		push_job.skip   = too_heavy || (active_cap == '0);

		items.ready = !full;
		push        = items.valid && !full;
	end

endmodule

`default_nettype wire

FILE: sv/kbv_back.sv
// ---------------------------------------------------------------------------
// kbv_back
// Sweeps the best-value table for each job not marked skip, emits the result after
// the last item of a problem and then clears the table.
// ---------------------------------------------------------------------------
`default_nettype none

module kbv_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire kbv_pkg::kbv_job_t job,
	input  wire logic           job_valid,
	output logic                job_pop,
	kbv_result_if.source        results
);
	import kbv_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SWEEP  = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_READ   = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0]          state_q;
	kbv_job_t            job_q;
	logic [ADDR_W-1:0]   j_q;
	logic [ADDR_W-1:0]   lo_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                sat_q;

	// table memory and its registered read data
	logic [RESULT_W-1:0] mem [DEPTH];
	logic [RESULT_W-1:0] rd_a_s1;
	logic [RESULT_W-1:0] rd_b_s1;
	logic                valid_s1;
	logic [ADDR_W-1:0]   idx_s1;

	logic                rd_en_a;
	logic                rd_en_b;
	logic [ADDR_W-1:0]   rd_addr_a;
	logic [ADDR_W-1:0]   rd_addr_b;
	logic [RESULT_W:0]   sum;
	logic [RESULT_W-1:0] sum_clamped;
	logic [RESULT_W-1:0] new_val;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [RESULT_W-1:0] wdata;
	logic                out_load;
	logic [ADDR_W-1:0]   job_lo;

	logic                out_valid_q;
	logic [RESULT_W-1:0] best_value_q;
	logic                saturated_q;

	// read, update and write selection
	always_comb begin
		job_pop   = (state_q == ST_IDLE) && job_valid;
		job_lo    = (job.weight == '0) ? ADDR_W'(1) : job.weight;

		rd_en_a   = (state_q == ST_SWEEP) || (state_q == ST_READ);
		rd_addr_a = (state_q == ST_READ) ? job_q.cap : j_q;
		rd_en_b   = (state_q == ST_SWEEP);
		rd_addr_b = j_q - job_q.weight;

		// take the item on top of the entry one weight below, saturating
		sum         = {1'b0, rd_b_s1} + (RESULT_W + 1)'(job_q.value);
		sum_clamped = sum[RESULT_W] ? {RESULT_W{1'b1}} : sum[RESULT_W-1:0];
		new_val     = (sum_clamped > rd_a_s1) ? sum_clamped : rd_a_s1;

		we    = (state_q == ST_CLEAR) || valid_s1;
		waddr = (state_q == ST_CLEAR) ? clr_q : idx_s1;
		wdata = (state_q == ST_CLEAR) ? '0 : new_val;

		out_load = (state_q == ST_RESULT) && (!out_valid_q || results.ready);

		results.valid      = out_valid_q;
		results.best_value = best_value_q;
		results.saturated  = saturated_q;
	end

	// table memory, one write and two reads a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en_a) begin
			rd_a_s1 <= mem[rd_addr_a];
		end
		if (rd_en_b) begin
			rd_b_s1 <= mem[rd_addr_b];
		end
	end

	// job and result payload
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
			lo_q  <= job_lo;
		end
		if (state_q == ST_SWEEP) begin
			idx_s1 <= j_q;
		end
		if (out_load) begin
			best_value_q <= rd_a_s1;
			saturated_q  <= sat_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			j_q         <= '0;
			valid_s1    <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_SWEEP);

			if (valid_s1 && sum[RESULT_W]) begin
				sat_q <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (job_valid) begin
						j_q <= job.cap;
						if (!job.skip) begin
							state_q <= ST_SWEEP;
						end else if (job.last) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_SWEEP: begin
					j_q <= j_q - 1'b1;
					if (j_q == lo_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= job_q.last ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_load) begin
						sat_q   <= 1'b0;
						clr_q   <= '0;
						state_q <= ST_CLEAR;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// sweep index stays between the lowest fitting entry and the capacity
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> (j_q >= lo_q) && (j_q <= job_q.cap))
		else $error("sweep index out of range");

	// entry zero is never updated by a sweep
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> idx_s1 != '0)
		else $error("sweep wrote entry zero");

	// result hand-off clears the flag and starts the clearing pass
	a_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> !sat_q && state_q == ST_CLEAR && clr_q == '0)
		else $error("result did not start clearing");

	// clearing writes never collide with sweep writes
	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !valid_s1)
		else $error("sweep write during clearing");

endmodule

`default_nettype wire

FILE: sv/knapsack_01_best_value.sv
// Knapsack best value: items (weight, value, last flag) enter through a short
// queue and each one sweeps the table of best values from the configured
// capacity down to its weight, or to entry one for a weight of zero, one table
// entry per cycle through a two-read, one-write table memory; an item heavier
// than the capacity, or any item when the capacity is zero, sweeps nothing.
// After an item marked last the entry at the capacity is read, registered and
// offered as a result, with the flag that tells whether any sum was clamped
// at the 32-bit maximum; the table is then wiped by a clearing pass over all
// 1024 entries, and the same pass runs after reset. Items are still taken into
// the queue during a sweep or a clearing pass while the queue has room.
// Write the capacity only while the block is idle.
// ---------------------------------------------------------------------------
// knapsack_01_best_value
// Top level: 0/1 knapsack best value by dynamic programming.
// ---------------------------------------------------------------------------
`default_nettype none

module knapsack_01_best_value (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	kbv_item_if.sink                        items,
	kbv_result_if.source                    results,
	input  wire logic                       capacity_we,
	input  wire logic [kbv_pkg::CAP_W-1:0]  capacity_wdata
);
	import kbv_pkg::*;

	logic     push;
	kbv_job_t push_job;
	logic     full;
	logic     pop;
	kbv_job_t head;
	logic     empty;

	// item intake and classification
	kbv_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.items          (items),
		.capacity_we    (capacity_we),
		.capacity_wdata (capacity_wdata),
		.push           (push),
		.push_job       (push_job),
		.full           (full)
	);

	// decoupling queue
	kbv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	// table sweep engine and result register
	kbv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head),
		.job_valid (!empty),
		.job_pop   (pop),
		.results   (results)
	);

endmodule

`default_nettype wire
